// ===== sv/pvrs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvrs_pkg
// Types, command codes and preferred-series constants for the range stepper.
// ----------------------------------------------------------------------------
package pvrs_pkg;

  typedef enum logic [1:0] {
    CmdSetValue   = 2'd0,
    CmdStepUp     = 2'd1,
    CmdStepDown   = 2'd2,
    CmdSetChannel = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [8:0] new_value;
    logic [1:0] new_channel;
  } in_t;

  typedef struct packed {
    logic [8:0]  value;
    logic [1:0]  channel;
    logic [1:0]  range_pins;
    logic [11:0] dac_code;
    logic        dac_write;
  } out_t;

  // Next state and result of one item, from the step unit to the top level
  typedef struct packed {
    logic [8:0]  value;
    logic [1:0]  channel;
    logic [11:0] dac_code;
    logic        dac_write;
  } step_res_t;

  localparam int unsigned NumSeries  = 4;
  localparam int unsigned MaxEntries = 11;

  localparam logic [1:0] TopChannel    = 2'd3;
  localparam logic [1:0] BottomChannel = 2'd0;
  localparam logic [1:0] SeriesReset   = 2'd3;

  // Entries in hundredths; unused slots padded with all ones and masked by length
  localparam logic [8:0] SeriesTab [NumSeries][MaxEntries] = '{
    '{9'd50, 9'd100, 9'd200, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511,
      9'd511, 9'd511},
    '{9'd25, 9'd30, 9'd40, 9'd50, 9'd60, 9'd70, 9'd80, 9'd90, 9'd100,
      9'd150, 9'd200},
    '{9'd25, 9'd40, 9'd63, 9'd100, 9'd160, 9'd511, 9'd511, 9'd511, 9'd511,
      9'd511, 9'd511},
    '{9'd25, 9'd32, 9'd40, 9'd50, 9'd63, 9'd80, 9'd100, 9'd130, 9'd160,
      9'd200, 9'd511}
  };

  localparam logic [3:0] SeriesLen [NumSeries] = '{4'd3, 4'd11, 4'd5, 4'd10};

  // floor(v * 4096 / 330) = floor(v * 2048 / 165), by reciprocal 2^28 / 165
  // rounded up; exact for every 9-bit v.
  localparam logic [29:0] DacRecip = 30'd1626882;
  localparam logic [11:0] DacMax   = 12'hFFF;

  function automatic logic [11:0] dac_of(input logic [8:0] v);
    logic [29:0] prod;
    logic [12:0] q;
    prod = 30'(v) * DacRecip;
    q    = prod[29:17];
    return q[12] ? DacMax : q[11:0];
  endfunction

endpackage

// ===== sv/preferred_value_range_stepper.sv =====
// ----------------------------------------------------------------------------
// preferred_value_range_stepper
// Setpoint and range-channel stepper over a selectable preferred series.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
//   per transfer: set value, step up, step down or set channel. Output
//   channel (out_valid_o / out_stall_i / out_data_o) returns one result per
//   command: setpoint, channel, range-select pin levels, DAC code and a flag
//   telling whether the DAC was written.
//   The input transfer edge loads the input register, and the item then
//   moves into the result register, from which its result is offered.
//   Throughput: one transfer per cycle while the result register is not
//   stalled, as the step logic sits combinationally between the two
//   registers.
//   The scaling of a set value to a DAC code is done on the way into the
//   input register, so the step path holds only compares and selection.
//   Stalling: while the result register is full and stalled, an item waiting
//   in the input register holds and in_stall_o rises; with the result
//   register free, a new item is taken every cycle.
//   series_select is written via cfg_we_i / cfg_wdata_i; the user must do
//   so only while idle, which the block does not enforce. Reset: setpoint
//   and channel clear to 0, series to R10, both registers empty.
// ----------------------------------------------------------------------------
module preferred_value_range_stepper (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pvrs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pvrs_pkg::out_t out_data_o
);
  import pvrs_pkg::*;

  // input register
  logic        in_vld_q, in_vld_d;
  in_t         in_q;
  logic [11:0] nv_dac_q;

  // architectural state
  logic [1:0]  series_q;
  logic [8:0]  setpoint_q;
  logic [1:0]  channel_q;
  logic [11:0] dac_q;

  // result register
  logic        out_vld_q, out_vld_d;
  out_t        out_q;

  logic        in_take, advance;
  step_res_t   res;

  // Item moves on when the result register is empty or being drained
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  pvrs_step u_step (
    .item_i     (in_q),
    .nv_dac_i   (nv_dac_q),
    .series_i   (series_q),
    .setpoint_i (setpoint_q),
    .channel_i  (channel_q),
    .dac_i      (dac_q),
    .res_o      (res)
  );

  always_comb begin
    in_vld_d = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      series_q   <= SeriesReset;
      setpoint_q <= '0;
      channel_q  <= '0;
      dac_q      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        series_q <= cfg_wdata_i;
      end
      if (advance) begin
        setpoint_q <= res.value;
        channel_q  <= res.channel;
        dac_q      <= res.dac_code;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q     <= in_data_i;
      nv_dac_q <= dac_of(in_data_i.new_value);
    end
    if (advance) begin
      out_q.value      <= res.value;
      out_q.channel    <= res.channel;
      out_q.range_pins <= ~res.channel;  // A1:A0, both high on channel 0
      out_q.dac_code   <= res.dac_code;
      out_q.dac_write  <= res.dac_write;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/pvrs_step.sv =====
// ----------------------------------------------------------------------------
// pvrs_step
// Combinational next-state unit: series lookup by parallel compares.
// ----------------------------------------------------------------------------
module pvrs_step (
  input  pvrs_pkg::in_t       item_i,
  input  logic [11:0]         nv_dac_i,
  input  logic [1:0]          series_i,
  input  logic [8:0]          setpoint_i,
  input  logic [1:0]          channel_i,
  input  logic [11:0]         dac_i,
  output pvrs_pkg::step_res_t res_o
);
  import pvrs_pkg::*;

  logic [11:0] dac_rom [NumSeries][MaxEntries];
  logic [8:0]  row     [MaxEntries];
  logic [MaxEntries-1:0] gt, lt;
  logic [3:0]  len, last_idx, up_idx, down_idx, idx;
  logic [8:0]  first_val, last_val;
  logic        use_tab;

  // DAC codes of every series entry, folded to constants
  for (genvar s = 0; s < NumSeries; s++) begin : g_rom_s
    for (genvar e = 0; e < MaxEntries; e++) begin : g_rom_e
      assign dac_rom[s][e] = dac_of(SeriesTab[s][e]);
    end
  end

  assign len       = SeriesLen[series_i];
  assign last_idx  = len - 4'd1;

  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      row[i] = SeriesTab[series_i][i];
      gt[i]  = (4'(i) < len) && (row[i] > setpoint_i);
      lt[i]  = (4'(i) < len) && (row[i] < setpoint_i);
    end
  end

  assign first_val = row[0];
  assign last_val  = row[last_idx];

  // lowest entry above, highest entry below
  always_comb begin
    up_idx   = '0;
    down_idx = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (gt[i]) up_idx = 4'(i);
    end
    for (int i = 0; i < MaxEntries; i++) begin
      if (lt[i]) down_idx = 4'(i);
    end
  end

  always_comb begin
    res_o     = '{value: setpoint_i, channel: channel_i, dac_code: dac_i,
                  dac_write: 1'b0};
    idx       = '0;
    use_tab   = 1'b0;
    case (item_i.cmd)
      CmdSetValue: begin
        res_o.value    = item_i.new_value;
        res_o.dac_code = nv_dac_i;
      end
      CmdSetChannel: begin
        res_o.channel = item_i.new_channel;
      end
      CmdStepUp: begin
        if (setpoint_i >= last_val) begin
          if (channel_i != TopChannel) begin
            res_o.channel   = channel_i + 2'd1;
            idx             = '0;
            use_tab         = 1'b1;
            res_o.dac_write = 1'b1;
          end
        end else begin
          idx             = up_idx;
          use_tab         = 1'b1;
          res_o.dac_write = 1'b1;
        end
      end
      CmdStepDown: begin
        if (setpoint_i <= first_val) begin
          if (channel_i != BottomChannel) begin
            res_o.channel   = channel_i - 2'd1;
            idx             = last_idx;
            use_tab         = 1'b1;
            res_o.dac_write = 1'b1;
          end
        end else begin
          idx             = down_idx;
          use_tab         = 1'b1;
          res_o.dac_write = 1'b1;
        end
      end
      default: begin
        use_tab = 1'b0;
      end
    endcase
    if (use_tab) begin
      res_o.value    = row[idx];
      res_o.dac_code = dac_rom[series_i][idx];
    end
  end

endmodule

// ===== sv/pvrs_checker.sv =====
// ----------------------------------------------------------------------------
// pvrs_checker
// Port-level checks on the range stepper, bound to the top level.
// ----------------------------------------------------------------------------
module pvrs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input pvrs_pkg::out_t out_data_o
);
  import pvrs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // every input transfer shows up as a result at the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("result missing after input transfer");

  // DAC code always tracks the reported setpoint
  a_dac_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.dac_code == dac_of(out_data_o.value))
    else $error("DAC code does not match setpoint");

endmodule

bind preferred_value_range_stepper pvrs_checker u_pvrs_checker (.*);
